// File: hdl/rgbc_pkg.sv
// Package for the RGBA 2-D convolution block: shared types and constants.
// No dependencies; compile first.
package rgbc_pkg;
    localparam int CFG_W = 60;
    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_KSIZE = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ROW0 = 3'd3;
    localparam int PACKED_ROWS = 5;
    localparam int COEF_W = 12;
    localparam logic OP_PIXEL = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
        logic [7:0] alpha;
    } t_pix;

    typedef struct packed {
        logic       op;
        logic [7:0] in_red;
        logic [7:0] in_green;
        logic [7:0] in_blue;
        logic [7:0] in_alpha;
    } t_in;

    typedef struct packed {
        logic [7:0] out_red;
        logic [7:0] out_green;
        logic [7:0] out_blue;
        logic [7:0] out_alpha;
        logic       frame_end;
    } t_out;

    // Round a Q.8 sum toward zero and clamp to a byte.
    function automatic logic [7:0] finish(input logic signed [31:0] s);
        logic signed [31:0] q;
        q = s >>> 8;
        if (s <= 0) return 8'd0;
        if (q > 32'sd255) return 8'd255;
        return q[7:0];
    endfunction
endpackage

// File: hdl/rgbc_stream_if.sv
// Valid/ready channel interface carrying one payload type.
// No dependencies.
interface rgbc_stream_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;
    modport source(output valid, output data, input ready);
    modport sink(input valid, input data, output ready);
endinterface

// File: hdl/rgbc_line_mem.sv
// Line store bank with one write and one read port; one per ring row and column.
// Depends on rgbc_pkg.
module rgbc_line_mem
    import rgbc_pkg::*;
#(
    parameter int DEPTH = 4096,
    parameter int AW = 12
) (
    input  logic          i_clk,
    input  logic          i_we,
    input  logic [AW-1:0] i_waddr,
    input  t_pix          i_wdata,
    input  logic          i_re,
    input  logic [AW-1:0] i_raddr,
    output t_pix          o_rdata
);
    t_pix mem [DEPTH];
    t_pix r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) mem[i_waddr] <= i_wdata;
    end
    // registered read port, held while not enabled
    always_ff @(posedge i_clk) begin
        if (i_re) r_rdata <= mem[i_raddr];
    end
    assign o_rdata = r_rdata;
endmodule

// File: hdl/rgbc_mac.sv
// Multiply-accumulate of one window row for three colors, registered.
// Depends on rgbc_pkg.
module rgbc_mac
    import rgbc_pkg::*;
#(
    parameter int K = 5
) (
    input  logic                     i_clk,
    input  logic                     i_en,
    input  t_pix                     i_pix [K],
    input  logic [K-1:0]             i_use,
    input  logic signed [COEF_W-1:0] i_coef [K],
    output logic signed [31:0]       o_sum [3]
);
    logic signed [31:0] n_sum [3];
    logic signed [31:0] r_sum [3];

    // sum products of the lanes in use
    always_comb begin
        for (int c = 0; c < 3; c++) n_sum[c] = '0;
        for (int j = 0; j < K; j++) begin
            if (i_use[j]) begin
                n_sum[0] += 32'(i_coef[j]) * 32'($signed({1'b0, i_pix[j].red}));
                n_sum[1] += 32'(i_coef[j]) * 32'($signed({1'b0, i_pix[j].green}));
                n_sum[2] += 32'(i_coef[j]) * 32'($signed({1'b0, i_pix[j].blue}));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) r_sum <= n_sum;
    end
    assign o_sum = r_sum;
endmodule

// File: hdl/rgba_convolution_2d_top.sv
// Top level of the RGBA 2-D convolution: counters, line store, window, MAC tree.
// Depends on rgbc_pkg, rgbc_stream_if, rgbc_line_mem, rgbc_mac.
//
// Usage: pixels enter in raster order on s_in (op=0); after the frame, flush
// transfers (op=1) drain the pending outputs. Each accepted item yields zero
// or one result on m_out. Output pixel m appears for input transfer m+lag,
// lag = h*W + h with h = kernel_size/2; frame_end marks the last one.
// Throughput: one item per clock while the receiver does not stall. An input
// transfer passes the registered stages in order: the line-store read, the
// per-row multiply-accumulate, and the row sum and clamp into the output
// register. The pixel written at the transfer edge is forwarded
// to the taps. The line store is a ring of 3*h_max+1 rows split into one
// memory per ring row and kernel column, each read once per cycle, which
// sets the one-item rate.
// Reset clears counters and pipeline valids; geometry resets to 3 x 1024 x 1024
// and coefficients to zero. Line-store content is undefined until written.
// When the receiver stalls, the whole pipeline holds and s_in.ready falls;
// an output register and the enable on every stage keep results in order.
// Configuration is written through i_cfg_we/i_cfg_idx/i_cfg_data while idle.
module rgba_convolution_2d_top
    import rgbc_pkg::*;
#(
    parameter int MAX_KERNEL = 5,
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HEIGHT = 1024
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data,
    rgbc_stream_if.sink          s_in,
    rgbc_stream_if.source        m_out
);
    localparam int HM = MAX_KERNEL / 2;
    localparam int RING = 3 * HM + 1;
    localparam int XW = $clog2(MAX_WIDTH + 1);
    localparam int YW = $clog2(MAX_HEIGHT + 1) + 1;
    localparam int CW = $clog2(MAX_WIDTH);
    localparam int RW = (RING > 1) ? $clog2(RING) : 1;
    localparam int KW = $clog2(MAX_KERNEL + 1);
    localparam int NW = XW + YW + 1;

    // configuration registers
    logic [2:0]  r_ksize;
    logic [10:0] r_width, r_height;
    logic [CFG_W-1:0] r_krow [PACKED_ROWS];
    logic restart;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ksize <= 3'd3;
            r_width <= 11'd1024;
            r_height <= 11'd1024;
            for (int i = 0; i < PACKED_ROWS; i++) r_krow[i] <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_KSIZE:  r_ksize <= i_cfg_data[2:0];
                REG_WIDTH:  r_width <= i_cfg_data[10:0];
                REG_HEIGHT: r_height <= i_cfg_data[10:0];
                default: begin
                    if (i_cfg_idx >= REG_ROW0
                        && int'(i_cfg_idx) < int'(REG_ROW0) + PACKED_ROWS)
                        r_krow[3'(i_cfg_idx - REG_ROW0)] <= i_cfg_data;
                end
            endcase
        end
    end
    assign restart = i_cfg_we && (i_cfg_idx == REG_KSIZE || i_cfg_idx == REG_WIDTH
                                  || i_cfg_idx == REG_HEIGHT);

    // effective geometry
    logic [KW-1:0] k;
    logic [KW-1:0] h;
    logic [XW-1:0] w;
    logic [YW-1:0] hgt;
    always_comb begin
        if (r_ksize == 3'd0) k = KW'(1);
        else if (32'(r_ksize) > MAX_KERNEL) k = KW'(MAX_KERNEL);
        else k = KW'(r_ksize);
        h = k >> 1;
        if (r_width == 11'd0) w = XW'(1);
        else if (32'(r_width) > MAX_WIDTH) w = XW'(MAX_WIDTH);
        else w = XW'(r_width);
        if (r_height == 11'd0) hgt = YW'(1);
        else if (32'(r_height) > MAX_HEIGHT) hgt = YW'(MAX_HEIGHT);
        else hgt = YW'(r_height);
    end

    // stream counters: in position, raster count, ring row, output position
    logic [XW-1:0] r_icol, r_ocol;
    logic [YW-1:0] r_iline, r_oline;
    logic [NW-1:0] r_n, lag;
    logic [RW-1:0] r_iring, r_oring;
    logic stall, adv, acc, frame_in, emit, last;

    // pipeline stage valids (s1: memory read, s2: row MAC, s3: output)
    logic r_v1, r_v2, r_ov;
    t_out r_out;
    assign stall = r_ov && !m_out.ready;
    assign adv = !stall;
    assign s_in.ready = adv && i_rst_n;
    assign acc = s_in.valid && s_in.ready;
    assign frame_in = r_iline < hgt;
    assign lag = NW'(h) * NW'(w) + NW'(h);
    assign emit = acc && !(s_in.data.op == OP_FLUSH && frame_in) && r_n >= lag;
    assign last = (r_oline == hgt - 1'b1) && (r_ocol == w - 1'b1);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || restart) begin
            r_icol <= '0; r_iline <= '0; r_ocol <= '0; r_oline <= '0;
            r_n <= '0; r_iring <= '0; r_oring <= '0;
        end else if (acc && !(s_in.data.op == OP_FLUSH && frame_in)) begin
            if (emit && last) begin
                r_icol <= '0; r_iline <= '0; r_ocol <= '0; r_oline <= '0;
                r_n <= '0; r_iring <= '0; r_oring <= '0;
            end else begin
                r_n <= r_n + 1'b1;
                if (r_icol + 1'b1 >= w) begin
                    r_icol <= '0;
                    r_iline <= r_iline + 1'b1;
                    r_iring <= (32'(r_iring) == RING - 1) ? '0 : r_iring + 1'b1;
                end else begin
                    r_icol <= r_icol + 1'b1;
                end
                if (emit) begin
                    if (r_ocol + 1'b1 >= w) begin
                        r_ocol <= '0;
                        r_oline <= r_oline + 1'b1;
                        r_oring <= (32'(r_oring) == RING - 1) ? '0 : r_oring + 1'b1;
                    end else begin
                        r_ocol <= r_ocol + 1'b1;
                    end
                end
            end
        end
    end

    // ring row and validity of each kernel row of the window
    logic [RW-1:0] ring_of [MAX_KERNEL];
    logic [MAX_KERNEL-1:0] row_ok;
    logic [MAX_KERNEL-1:0] col_ok;
    logic [CW-1:0] col_of [MAX_KERNEL];
    always_comb begin
        for (int f = 0; f < MAX_KERNEL; f++) begin
            logic signed [YW+1:0] y;
            logic signed [XW+1:0] x;
            logic signed [RW+2:0] rr;
            y = $signed({2'b0, r_oline}) + (YW+2)'(f) - (YW+2)'(h);
            x = $signed({2'b0, r_ocol}) + (XW+2)'(f) - (XW+2)'(h);
            rr = $signed({3'b0, r_oring}) + (RW+3)'(f) - (RW+3)'(h);
            if (rr < 0) rr = rr + (RW+3)'(RING);
            else if (rr >= (RW+3)'(RING)) rr = rr - (RW+3)'(RING);
            ring_of[f] = RW'(rr);
            row_ok[f] = (f < k) && (y >= 0) && (y < $signed({2'b0, hgt}));
            col_ok[f] = (f < k) && (x >= 0) && (x < $signed({2'b0, w}));
            col_of[f] = CW'(x);
        end
    end

    // one memory per (ring row, kernel column) so every tap reads one port
    t_pix rd [RING][MAX_KERNEL];
    logic [RW-1:0] r_ring1 [MAX_KERNEL];
    logic [MAX_KERNEL-1:0] r_row1, r_col1;
    logic [RW-1:0] r_cring1;
    logic [CW-1:0] r_cols1 [MAX_KERNEL];
    logic [KW-1:0] r_h1;
    logic [7:0] cent_alpha;
    t_pix cent_pix;
    logic r_last1, r_last2;
    logic [7:0] r_alpha2;
    logic wr_en;
    t_pix wr_pix;
    logic r_fwe1;
    logic [RW-1:0] r_fring1;
    logic [CW-1:0] r_fcol1;
    t_pix r_fpix1;

    assign wr_en = acc && frame_in && s_in.data.op == OP_PIXEL;
    assign wr_pix = {s_in.data.in_red, s_in.data.in_green,
                     s_in.data.in_blue, s_in.data.in_alpha};

    for (genvar r = 0; r < RING; r++) begin : g_ring
        for (genvar c = 0; c < MAX_KERNEL; c++) begin : g_col
            rgbc_line_mem #(.DEPTH(MAX_WIDTH), .AW(CW)) u_mem (
                .i_clk(i_clk),
                .i_we(wr_en && r_iring == RW'(r)),
                .i_waddr(CW'(r_icol)),
                .i_wdata(wr_pix),
                .i_re(adv),
                .i_raddr(col_of[c]),
                .o_rdata(rd[r][c])
            );
        end
    end

    // stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_fwe1 <= 1'b0;
        end else if (adv) begin
            r_v1 <= emit;
            r_fwe1 <= wr_en;
        end
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_ring1 <= ring_of;
            r_row1 <= row_ok;
            r_col1 <= col_ok;
            r_cols1 <= col_of;
            r_cring1 <= r_oring;
            r_h1 <= h;
            r_last1 <= last;
            r_fring1 <= r_iring;
            r_fcol1 <= CW'(r_icol);
            r_fpix1 <= wr_pix;
        end
    end

    // stage 2: per-row MAC, taps take the pixel written at the read edge
    logic signed [31:0] rsum [MAX_KERNEL][3];
    for (genvar f = 0; f < MAX_KERNEL; f++) begin : g_row
        t_pix tap [MAX_KERNEL];
        logic signed [COEF_W-1:0] cf [MAX_KERNEL];
        for (genvar c = 0; c < MAX_KERNEL; c++) begin : g_tap
            assign tap[c] = (r_fwe1 && r_fring1 == r_ring1[f] && r_fcol1 == r_cols1[c])
                            ? r_fpix1 : rd[r_ring1[f]][c];
            if (f < PACKED_ROWS && c < 5) begin : g_c
                assign cf[c] = $signed(r_krow[f][COEF_W*c +: COEF_W]);
            end else begin : g_z
                assign cf[c] = '0;
            end
        end
        rgbc_mac #(.K(MAX_KERNEL)) u_mac (
            .i_clk(i_clk), .i_en(adv), .i_pix(tap),
            .i_use(r_row1[f] ? r_col1 : '0), .i_coef(cf), .o_sum(rsum[f])
        );
    end

    // centre pixel sits in kernel column h of the output row
    assign cent_pix = (r_fwe1 && r_fring1 == r_cring1 && r_fcol1 == r_cols1[r_h1])
                      ? r_fpix1 : rd[r_cring1][r_h1];
    assign cent_alpha = cent_pix.alpha;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v2 <= 1'b0;
        else if (adv) r_v2 <= r_v1;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_alpha2 <= cent_alpha;
            r_last2 <= r_last1;
        end
    end

    // stage 3: row sum, round, clamp into output register
    logic signed [31:0] tot [3];
    always_comb begin
        for (int c = 0; c < 3; c++) begin
            tot[c] = '0;
            for (int f = 0; f < MAX_KERNEL; f++) tot[c] += rsum[f][c];
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_ov <= 1'b0;
        else if (adv) r_ov <= r_v2;
    end
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out.out_red <= finish(tot[0]);
            r_out.out_green <= finish(tot[1]);
            r_out.out_blue <= finish(tot[2]);
            r_out.out_alpha <= r_alpha2;
            r_out.frame_end <= r_last2;
        end
    end
    assign m_out.valid = r_ov;
    assign m_out.data = r_out;
endmodule

// File: hdl/rgbc_checker.sv
// Port-level checker for the convolution top level, bound to it.
// Depends on rgba_convolution_2d_top.
module rgbc_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic [32:0] i_out_data
);
    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_data))
        else $error("result changed under stall");
    // input is blocked while a result is stalled
    a_bp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |-> !i_in_ready)
        else $error("input taken during stall");
    // no result right out of reset
    a_rst: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result after reset");
endmodule

bind rgba_convolution_2d_top rgbc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .i_in_ready(s_in.ready),
    .i_out_valid(m_out.valid), .i_out_ready(m_out.ready), .i_out_data(m_out.data)
);
